### hw/rtl/isp_pkg.sv
package isp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W  = $clog2(STACK_DEPTH);
  localparam int RCNT_W = $clog2(MAX_RESULTS + 1);
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [RCNT_W-1:0] rcnt_t;
  typedef logic [QPTR_W-1:0] qptr_t;
  typedef logic [QCNT_W-1:0] qcnt_t;

  // incoming token kinds
  localparam logic [2:0] TOK_NUM   = 3'd0;
  localparam logic [2:0] TOK_OP    = 3'd1;
  localparam logic [2:0] TOK_OPEN  = 3'd2;
  localparam logic [2:0] TOK_CLOSE = 3'd3;
  localparam logic [2:0] TOK_END   = 3'd4;

  // result kinds
  localparam logic [1:0] OUT_NUM = 2'd0;
  localparam logic [1:0] OUT_OP  = 2'd1;
  localparam logic [1:0] OUT_ERR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  typedef enum logic [2:0] {
    CMD_NUM,
    CMD_OP,
    CMD_OPEN,
    CMD_CLOSE,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  code;
    logic [2:0]  prec;
    logic [63:0] value;
  } cmd_t;

  typedef struct packed {
    logic       is_open;
    logic [3:0] code;
    logic [2:0] prec;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  operator_code;
    logic [63:0] value;
    logic [1:0]  error_code;
    logic        last_of_run;
    logic        expression_end;
  } result_t;

endpackage

### hw/rtl/isp_front.sv
module isp_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_token_kind,
  input  logic [3:0]    in_operator_code,
  input  logic [2:0]    in_op_precedence,
  input  logic [63:0]   in_number_value,
  input  logic          queue_full,
  output logic          enq_valid,
  output isp_pkg::cmd_t enq_cmd
);

  logic known;

  assign in_ready = !queue_full;

  always_comb begin
    known         = 1'b1;
    enq_cmd.kind  = isp_pkg::CMD_NUM;
    enq_cmd.code  = in_operator_code;
    enq_cmd.prec  = in_op_precedence;
    enq_cmd.value = in_number_value;
    case (in_token_kind)
      isp_pkg::TOK_NUM:   enq_cmd.kind = isp_pkg::CMD_NUM;
      isp_pkg::TOK_OP:    enq_cmd.kind = isp_pkg::CMD_OP;
      isp_pkg::TOK_OPEN:  enq_cmd.kind = isp_pkg::CMD_OPEN;
      isp_pkg::TOK_CLOSE: enq_cmd.kind = isp_pkg::CMD_CLOSE;
      isp_pkg::TOK_END:   enq_cmd.kind = isp_pkg::CMD_END;
      default:            known = 1'b0;
    endcase
  end

  // unknown kinds are taken and dropped here
  assign enq_valid = in_valid && in_ready && known;

endmodule

### hw/rtl/isp_queue.sv
module isp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          enq_valid,
  input  isp_pkg::cmd_t enq_cmd,
  output logic          full,
  output logic          deq_valid,
  output isp_pkg::cmd_t deq_cmd,
  input  logic          deq_pop
);

  isp_pkg::cmd_t  store [isp_pkg::QUEUE_DEPTH];
  isp_pkg::qptr_t wr_ptr_r, wr_ptr_nxt;
  isp_pkg::qptr_t rd_ptr_r, rd_ptr_nxt;
  isp_pkg::qcnt_t count_r, count_nxt;
  logic           do_enq, do_deq;

  assign full      = (count_r == isp_pkg::qcnt_t'(isp_pkg::QUEUE_DEPTH));
  assign deq_valid = (count_r != '0);
  assign deq_cmd   = store[rd_ptr_r];
  assign do_enq    = enq_valid && !full;
  assign do_deq    = deq_pop && deq_valid;

  function automatic isp_pkg::qptr_t ptr_inc(input isp_pkg::qptr_t p);
    if (p == isp_pkg::qptr_t'(isp_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + isp_pkg::qptr_t'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = do_enq ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_deq ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_enq && !do_deq) begin
      count_nxt = count_r + isp_pkg::qcnt_t'(1);
    end else if (do_deq && !do_enq) begin
      count_nxt = count_r - isp_pkg::qcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq) begin
      store[wr_ptr_r] <= enq_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hw/rtl/isp_back.sv
module isp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  isp_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output isp_pkg::result_t out_res
);

  // top of stack lives in a register, the rest in the array below it
  isp_pkg::entry_t  stack_mem [isp_pkg::STACK_DEPTH];
  isp_pkg::entry_t  top_r, top_nxt;
  isp_pkg::cnt_t    cnt_r, cnt_nxt;
  isp_pkg::cnt_t    open_cnt_r, open_cnt_nxt;
  isp_pkg::rcnt_t   res_cnt_r, res_cnt_nxt;
  logic             out_valid_r;
  isp_pkg::result_t out_res_r;

  isp_pkg::entry_t  below;
  isp_pkg::entry_t  new_entry;
  isp_pkg::cnt_t    below_cnt, wr_cnt, op_cnt;
  isp_pkg::result_t res;
  logic             emit, want, go, done, nat_last;
  logic             do_pop, do_push, do_replace, do_clear;
  logic             top_is_op, can_out, not_full;

  assign below_cnt = cnt_r - isp_pkg::cnt_t'(2);
  assign wr_cnt    = cnt_r - isp_pkg::cnt_t'(1);
  assign below     = stack_mem[below_cnt[isp_pkg::IDX_W-1:0]];
  assign op_cnt    = cnt_r - open_cnt_r;
  assign top_is_op = (cnt_r != '0) && !top_r.is_open;
  assign not_full  = (cnt_r < isp_pkg::cnt_t'(isp_pkg::STACK_DEPTH));
  assign can_out   = !out_valid_r || out_ready;

  always_comb begin
    emit       = 1'b0;
    nat_last   = 1'b0;
    done       = 1'b0;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    do_replace = 1'b0;
    do_clear   = 1'b0;
    new_entry  = '{is_open: 1'b0, code: cmd.code, prec: cmd.prec};
    res        = '0;
    case (cmd.kind)
      isp_pkg::CMD_NUM: begin
        emit      = 1'b1;
        nat_last  = 1'b1;
        done      = 1'b1;
        res.kind  = isp_pkg::OUT_NUM;
        res.value = cmd.value;
      end
      isp_pkg::CMD_OP: begin
        if (top_is_op && (top_r.prec >= cmd.prec)) begin
          emit              = 1'b1;
          res.kind          = isp_pkg::OUT_OP;
          res.operator_code = top_r.code;
          nat_last = (cnt_r == isp_pkg::cnt_t'(1)) || below.is_open ||
                     (below.prec < cmd.prec);
          // on the final pop the new operator takes the freed slot
          if (nat_last) begin
            do_replace = 1'b1;
            done       = 1'b1;
          end else begin
            do_pop = 1'b1;
          end
        end else if (not_full) begin
          do_push = 1'b1;
          done    = 1'b1;
        end else begin
          emit           = 1'b1;
          nat_last       = 1'b1;
          done           = 1'b1;
          res.kind       = isp_pkg::OUT_ERR;
          res.error_code = isp_pkg::ERR_OVERFLOW;
        end
      end
      isp_pkg::CMD_OPEN: begin
        new_entry = '{is_open: 1'b1, code: 4'd0, prec: 3'd0};
        if (not_full) begin
          do_push = 1'b1;
        end else begin
          emit           = 1'b1;
          nat_last       = 1'b1;
          res.kind       = isp_pkg::OUT_ERR;
          res.error_code = isp_pkg::ERR_OVERFLOW;
        end
        done = 1'b1;
      end
      isp_pkg::CMD_CLOSE: begin
        if (open_cnt_r == '0) begin
          emit           = 1'b1;
          nat_last       = 1'b1;
          done           = 1'b1;
          res.kind       = isp_pkg::OUT_ERR;
          res.error_code = isp_pkg::ERR_UNMATCHED;
        end else if (top_r.is_open) begin
          do_pop = 1'b1;
          done   = 1'b1;
        end else begin
          emit              = 1'b1;
          do_pop            = 1'b1;
          res.kind          = isp_pkg::OUT_OP;
          res.operator_code = top_r.code;
          nat_last          = below.is_open;
        end
      end
      isp_pkg::CMD_END: begin
        if (op_cnt == '0) begin
          // only open parens left: drop them at once
          do_clear = 1'b1;
          done     = 1'b1;
        end else if (top_r.is_open) begin
          do_pop = 1'b1;
        end else begin
          emit              = 1'b1;
          res.kind          = isp_pkg::OUT_OP;
          res.operator_code = top_r.code;
          nat_last          = (op_cnt == isp_pkg::cnt_t'(1));
          if (nat_last) begin
            do_clear = 1'b1;
            done     = 1'b1;
          end else begin
            do_pop = 1'b1;
          end
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
    res.last_of_run    = nat_last ||
                         (res_cnt_r == isp_pkg::rcnt_t'(isp_pkg::MAX_RESULTS - 1));
    res.expression_end = res.last_of_run && (cmd.kind == isp_pkg::CMD_END);
  end

  // results past the per-token limit are dropped, the pops still happen
  assign want    = emit && (res_cnt_r < isp_pkg::rcnt_t'(isp_pkg::MAX_RESULTS));
  assign go      = cmd_valid && (!want || can_out);
  assign cmd_pop = go && done;

  always_comb begin
    top_nxt      = top_r;
    cnt_nxt      = cnt_r;
    open_cnt_nxt = open_cnt_r;
    res_cnt_nxt  = res_cnt_r;
    if (go) begin
      if (done) begin
        res_cnt_nxt = '0;
      end else if (want) begin
        res_cnt_nxt = res_cnt_r + isp_pkg::rcnt_t'(1);
      end
      if (do_clear) begin
        cnt_nxt      = '0;
        open_cnt_nxt = '0;
      end else if (do_pop) begin
        top_nxt = below;
        cnt_nxt = cnt_r - isp_pkg::cnt_t'(1);
        if (top_r.is_open) begin
          open_cnt_nxt = open_cnt_r - isp_pkg::cnt_t'(1);
        end
      end else if (do_push) begin
        top_nxt = new_entry;
        cnt_nxt = cnt_r + isp_pkg::cnt_t'(1);
        if (new_entry.is_open) begin
          open_cnt_nxt = open_cnt_r + isp_pkg::cnt_t'(1);
        end
      end else if (do_replace) begin
        top_nxt = new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && do_push && (cnt_r != '0)) begin
      stack_mem[wr_cnt[isp_pkg::IDX_W-1:0]] <= top_r;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (go && want) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      open_cnt_r  <= '0;
      res_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      open_cnt_r <= open_cnt_nxt;
      res_cnt_r  <= res_cnt_nxt;
      if (go && want) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### hw/rtl/infix_to_postfix_converter.sv
// the first result of a token passes through the command queue and the output register
// throughput while the output is not stalled: one number, push or open paren per cycle;
// operator pops, close paren pops and end drains: one stack entry per cycle (one port)
// an end token drops leftover open parens all at once when no operator remains
// reset (rst_n low, synchronous) empties the stack, the command queue and the output
module infix_to_postfix_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_token_kind,
  input  logic [3:0]  in_operator_code,
  input  logic [2:0]  in_op_precedence,
  input  logic [63:0] in_number_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_operator,
  output logic [63:0] out_value,
  output logic [1:0]  out_error_code,
  output logic        out_last_of_run,
  output logic        out_expression_end
);

  isp_pkg::cmd_t    enq_cmd, deq_cmd;
  isp_pkg::result_t res;
  logic             enq_valid, queue_full, deq_valid, deq_pop;

  isp_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_token_kind    (in_token_kind),
    .in_operator_code (in_operator_code),
    .in_op_precedence (in_op_precedence),
    .in_number_value  (in_number_value),
    .queue_full       (queue_full),
    .enq_valid        (enq_valid),
    .enq_cmd          (enq_cmd)
  );

  isp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq_valid (enq_valid),
    .enq_cmd   (enq_cmd),
    .full      (queue_full),
    .deq_valid (deq_valid),
    .deq_cmd   (deq_cmd),
    .deq_pop   (deq_pop)
  );

  isp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (deq_valid),
    .cmd       (deq_cmd),
    .cmd_pop   (deq_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_kind           = res.kind;
  assign out_operator       = res.operator_code;
  assign out_value          = res.value;
  assign out_error_code     = res.error_code;
  assign out_last_of_run    = res.last_of_run;
  assign out_expression_end = res.expression_end;

endmodule

### hw/rtl/isp_checker.sv
module isp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [3:0]  out_operator,
  input logic [63:0] out_value,
  input logic [1:0]  out_error_code,
  input logic        out_last_of_run,
  input logic        out_expression_end
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_operator) && $stable(out_value) && $stable(out_error_code) &&
    $stable(out_last_of_run) && $stable(out_expression_end))
    else $error("result changed while stalled");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_expression_end |-> out_last_of_run)
    else $error("expression end without last of run");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == isp_pkg::OUT_ERR) == (out_error_code != isp_pkg::ERR_NONE)))
    else $error("error code disagrees with result kind");

  a_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != isp_pkg::OUT_NUM |-> out_value == '0)
    else $error("value on a non-number result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind infix_to_postfix_converter isp_checker u_isp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_kind           (out_kind),
  .out_operator       (out_operator),
  .out_value          (out_value),
  .out_error_code     (out_error_code),
  .out_last_of_run    (out_last_of_run),
  .out_expression_end (out_expression_end)
);

### tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // token kinds the block has to ignore
  localparam logic [2:0] TOK_RSV5 = 3'd5;
  localparam logic [2:0] TOK_RSV6 = 3'd6;
  localparam logic [2:0] TOK_RSV7 = 3'd7;

  localparam int RAND_ITEMS   = 310;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [2:0]       kind;
    logic [3:0]       code;
    logic [2:0]       prec;
    logic [63:0]      value;
    logic             has_lit;
    isp_pkg::result_t lit;
  } token_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [3:0]       code;
    logic [2:0]       prec;
    logic [63:0]      value;
    logic [4:0]       reps;
    logic             ramp;
    logic             has_lit;
    isp_pkg::result_t lit;
  } dir_row_t;

  localparam int N_ROWS = 18;

  // ramp rows take code and precedence from the repeat index
  dir_row_t dir_rows [N_ROWS] = '{
    '{isp_pkg::TOK_CLOSE, 4'd0, 3'd0, 64'd0, 5'd1, 1'b0, 1'b1,
      '{isp_pkg::OUT_ERR, 4'd0, 64'd0, isp_pkg::ERR_UNMATCHED, 1'b1, 1'b0}},
    '{isp_pkg::TOK_NUM, 4'hf, 3'd7, 64'hffff_ffff_ffff_ffff, 5'd1, 1'b0, 1'b1,
      '{isp_pkg::OUT_NUM, 4'd0, 64'hffff_ffff_ffff_ffff, isp_pkg::ERR_NONE, 1'b1, 1'b0}},
    '{isp_pkg::TOK_OP, 4'hf, 3'd7, 64'hffff_ffff_ffff_ffff, 5'd1, 1'b0, 1'b0, '0},
    '{isp_pkg::TOK_OPEN, 4'hf, 3'd7, 64'hffff_ffff_ffff_ffff, 5'd1, 1'b0, 1'b0, '0},
    '{isp_pkg::TOK_NUM, 4'd0, 3'd0, 64'd0, 5'd1, 1'b0, 1'b1,
      '{isp_pkg::OUT_NUM, 4'd0, 64'd0, isp_pkg::ERR_NONE, 1'b1, 1'b0}},
    '{isp_pkg::TOK_OP, 4'd0, 3'd0, 64'd0, 5'd1, 1'b0, 1'b0, '0},
    '{isp_pkg::TOK_CLOSE, 4'h9, 3'd5, 64'h1234_5678_9abc_def0, 5'd1, 1'b0, 1'b0, '0},
    '{TOK_RSV5, 4'ha, 3'd5, 64'h5555_5555_5555_5555, 5'd1, 1'b0, 1'b0, '0},
    '{TOK_RSV6, 4'h5, 3'd2, 64'haaaa_aaaa_aaaa_aaaa, 5'd1, 1'b0, 1'b0, '0},
    '{TOK_RSV7, 4'hf, 3'd7, 64'hffff_ffff_ffff_ffff, 5'd1, 1'b0, 1'b0, '0},
    '{isp_pkg::TOK_OP, 4'd5, 3'd0, 64'd0, 5'd1, 1'b0, 1'b0, '0},
    '{isp_pkg::TOK_END, 4'd0, 3'd0, 64'd0, 5'd1, 1'b0, 1'b0, '0},
    '{isp_pkg::TOK_END, 4'hf, 3'd7, 64'hffff_ffff_ffff_ffff, 5'd1, 1'b0, 1'b0, '0},
    '{isp_pkg::TOK_OP, 4'd0, 3'd0, 64'd0, 5'd8, 1'b1, 1'b0, '0},
    '{isp_pkg::TOK_OPEN, 4'd0, 3'd0, 64'd0, 5'd1, 1'b0, 1'b0, '0},
    '{isp_pkg::TOK_OP, 4'd0, 3'd0, 64'd0, 5'd7, 1'b1, 1'b0, '0},
    '{isp_pkg::TOK_OPEN, 4'd0, 3'd0, 64'd0, 5'd1, 1'b0, 1'b1,
      '{isp_pkg::OUT_ERR, 4'd0, 64'd0, isp_pkg::ERR_OVERFLOW, 1'b1, 1'b0}},
    '{isp_pkg::TOK_END, 4'd0, 3'd0, 64'd0, 5'd1, 1'b0, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_token_kind = isp_pkg::TOK_NUM;
  logic [3:0]  in_operator_code = 4'd0;
  logic [2:0]  in_op_precedence = 3'd0;
  logic [63:0] in_number_value = 64'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [3:0]  out_operator;
  logic [63:0] out_value;
  logic [1:0]  out_error_code;
  logic        out_last_of_run;
  logic        out_expression_end;

  infix_to_postfix_converter u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_token_kind      (in_token_kind),
    .in_operator_code   (in_operator_code),
    .in_op_precedence   (in_op_precedence),
    .in_number_value    (in_number_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_operator       (out_operator),
    .out_value          (out_value),
    .out_error_code     (out_error_code),
    .out_last_of_run    (out_last_of_run),
    .out_expression_end (out_expression_end)
  );

  token_t           token_q [$];
  isp_pkg::result_t postfix_q [$];
  isp_pkg::result_t step_q [$];
  isp_pkg::entry_t  op_stack [isp_pkg::STACK_DEPTH];
  int unsigned      stack_cnt = 0;
  int               fail_cnt = 0;
  int               rand_items = 0;
  int               cycle_cnt = 0;
  int               send_idle = 0;
  int               recv_idle = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // ---------------- postfix predictor ----------------

  function automatic void add_result(logic [1:0] kind, logic [3:0] op, logic [63:0] val,
                                     logic [1:0] err);
    isp_pkg::result_t r;
    if (step_q.size() < isp_pkg::MAX_RESULTS) begin
      r = '{kind, op, val, err, 1'b0, 1'b0};
      step_q.push_back(r);
    end
  endfunction

  function automatic void push_entry(isp_pkg::entry_t e);
    if (stack_cnt >= isp_pkg::STACK_DEPTH) begin
      add_result(isp_pkg::OUT_ERR, 4'd0, 64'd0, isp_pkg::ERR_OVERFLOW);
    end else begin
      op_stack[stack_cnt] = e;
      stack_cnt++;
    end
  endfunction

  function automatic void predict_postfix(token_t tok);
    isp_pkg::entry_t  top;
    logic             found;
    logic             drained;
    isp_pkg::result_t r;
    step_q.delete();
    drained = 1'b0;
    found = 1'b0;
    case (tok.kind)
      isp_pkg::TOK_NUM: begin
        add_result(isp_pkg::OUT_NUM, 4'd0, tok.value, isp_pkg::ERR_NONE);
      end
      isp_pkg::TOK_OP: begin
        while (stack_cnt > 0) begin
          top = op_stack[stack_cnt - 1];
          if (top.is_open || top.prec < tok.prec) break;
          stack_cnt--;
          add_result(isp_pkg::OUT_OP, top.code, 64'd0, isp_pkg::ERR_NONE);
        end
        push_entry('{1'b0, tok.code, tok.prec});
      end
      isp_pkg::TOK_OPEN: begin
        push_entry('{1'b1, 4'd0, 3'd0});
      end
      isp_pkg::TOK_CLOSE: begin
        for (int i = 0; i < stack_cnt; i++)
          if (op_stack[i].is_open) found = 1'b1;
        if (!found) begin
          add_result(isp_pkg::OUT_ERR, 4'd0, 64'd0, isp_pkg::ERR_UNMATCHED);
        end else begin
          while (stack_cnt > 0) begin
            top = op_stack[stack_cnt - 1];
            stack_cnt--;
            if (top.is_open) break;
            add_result(isp_pkg::OUT_OP, top.code, 64'd0, isp_pkg::ERR_NONE);
          end
        end
      end
      isp_pkg::TOK_END: begin
        while (stack_cnt > 0) begin
          top = op_stack[stack_cnt - 1];
          stack_cnt--;
          if (!top.is_open) add_result(isp_pkg::OUT_OP, top.code, 64'd0, isp_pkg::ERR_NONE);
        end
        drained = 1'b1;
      end
      default: ;
    endcase
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.last_of_run = 1'b1;
      r.expression_end = drained;
      step_q.push_back(r);
    end
  endfunction

  // ---------------- stimulus ----------------

  function automatic token_t rand_token(logic [2:0] kind);
    token_t t;
    t = '0;
    t.kind = kind;
    t.code = 4'($urandom_range(15));
    t.prec = 3'($urandom_range(7));
    t.value = {$urandom, $urandom};
    return t;
  endfunction

  // a stray token now and then, any kind, ahead of the intended one
  function automatic void put_token(logic [2:0] kind);
    token_t t;
    if ($urandom_range(19) == 0) begin
      t = rand_token(3'($urandom_range(7)));
      token_q.push_back(t);
      if (t.kind <= isp_pkg::TOK_END) rand_items++;
    end
    token_q.push_back(rand_token(kind));
    rand_items++;
  endfunction

  function automatic void gen_expression();
    int n_ops;
    int depth;
    int max_depth;
    n_ops = $urandom_range(12);
    max_depth = ($urandom_range(7) == 0) ? 18 : 4;
    depth = 0;
    for (int i = 0; i <= n_ops; i++) begin
      while (depth < max_depth && $urandom_range(3) == 0) begin
        put_token(isp_pkg::TOK_OPEN);
        depth++;
      end
      put_token(isp_pkg::TOK_NUM);
      while (depth > 0 && $urandom_range(2) == 0) begin
        put_token(isp_pkg::TOK_CLOSE);
        depth--;
      end
      if (i < n_ops) put_token(isp_pkg::TOK_OP);
    end
    // leftover opens are sometimes left for the end token to drop
    if ($urandom_range(3) != 0) begin
      while (depth > 0) begin
        put_token(isp_pkg::TOK_CLOSE);
        depth--;
      end
    end
    if ($urandom_range(7) == 0) put_token(isp_pkg::TOK_CLOSE);
    put_token(isp_pkg::TOK_END);
  endfunction

  task automatic send_token(input token_t tok);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_token_kind <= tok.kind;
    in_operator_code <= tok.code;
    in_op_precedence <= tok.prec;
    in_number_value <= tok.value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_postfix(tok);
    if (tok.has_lit) begin
      postfix_q.push_back(tok.lit);
    end else begin
      foreach (step_q[i]) postfix_q.push_back(step_q[i]);
    end
    @(negedge clk);
  endtask

  // ---------------- result check ----------------

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t tb: %s expected %0h actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    isp_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (postfix_q.size() == 0) begin
        $display("%0t tb: transfer with nothing pending, expected none, actual %0d %0h %0h %0d",
                 $time, out_kind, out_operator, out_value, out_error_code);
        fail_cnt++;
      end else begin
        want = postfix_q.pop_front();
        check_field("kind", 64'(want.kind), 64'(out_kind));
        check_field("operator", 64'(want.operator_code), 64'(out_operator));
        check_field("value", want.value, out_value);
        check_field("error_code", 64'(want.error_code), 64'(out_error_code));
        check_field("last_of_run", 64'(want.last_of_run), 64'(out_last_of_run));
        check_field("expression_end", 64'(want.expression_end), 64'(out_expression_end));
      end
    end
  end

  initial begin
    token_t t;
    int     total;
    int     phase;
    for (int r = 0; r < N_ROWS; r++) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        t.kind = dir_rows[r].kind;
        t.code = dir_rows[r].ramp ? 4'(k) : dir_rows[r].code;
        t.prec = dir_rows[r].ramp ? 3'(k) : dir_rows[r].prec;
        t.value = dir_rows[r].value;
        t.has_lit = dir_rows[r].has_lit;
        t.lit = dir_rows[r].lit;
        token_q.push_back(t);
      end
    end
    while (rand_items < RAND_ITEMS) gen_expression();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    total = token_q.size();
    for (int idx = 0; idx < total; idx++) begin
      phase = (idx * 3) / total;
      send_idle = (phase == 0) ? 7 : (phase == 1) ? 62 : 0;
      recv_idle = (phase == 0) ? 62 : (phase == 1) ? 7 : 0;
      send_token(token_q[idx]);
    end
    in_valid <= 1'b0;

    while (postfix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && postfix_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/isp_pkg.sv
hw/rtl/isp_front.sv
hw/rtl/isp_queue.sv
hw/rtl/isp_back.sv
hw/rtl/infix_to_postfix_converter.sv
hw/rtl/isp_checker.sv
tb/sv/tb.sv
